### rtl/sma_pkg.sv
package sma_pkg;

	// Field widths of the instruction and result items.
	localparam int WORD_W = 32;
	localparam int KIND_W = 4;
	localparam int POS_W  = 3;
	localparam int STAT_W = 3;

	// Default stack depth in words.
	localparam int DEPTH_DEFAULT = 8;

	typedef logic [KIND_W-1:0]        kind_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [STAT_W-1:0]        status_t;

	// Instruction opcodes.
	localparam kind_t OP_PUSH = 4'd0;
	localparam kind_t OP_POP  = 4'd1;
	localparam kind_t OP_ADD  = 4'd2;
	localparam kind_t OP_SUB  = 4'd3;
	localparam kind_t OP_MUL  = 4'd4;
	localparam kind_t OP_DIV  = 4'd5;
	localparam kind_t OP_DUMP = 4'd6;
	localparam kind_t OP_PEEK = 4'd7;
	localparam kind_t OP_NOP  = 4'd8;
	localparam kind_t OP_EXIT = 4'd9;

	// Result status codes.
	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_FULL    = 3'd1;
	localparam status_t ST_EMPTY   = 3'd2;
	localparam status_t ST_DIVZERO = 3'd3;
	localparam status_t ST_HALTED  = 3'd4;

	// Operations of the shared arithmetic unit.
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 2'd0;
	localparam alu_op_t ALU_SUB = 2'd1;
	localparam alu_op_t ALU_MUL = 2'd2;
	localparam alu_op_t ALU_DIV = 2'd3;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_rsp_t;

endpackage

### rtl/sma_in_if.sv
interface sma_in_if;
	import sma_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	word_t push_value;

	modport source (output valid, output kind, output push_value, input ready);
	modport sink (input valid, input kind, input push_value, output ready);
endinterface

### rtl/sma_out_if.sv
interface sma_out_if;
	import sma_pkg::*;

	logic    valid;
	logic    ready;
	word_t   value;
	pos_t    position;
	status_t status;
	logic    last;

	modport source (output valid, output value, output position, output status, output last,
		input ready);
	modport sink (input valid, input value, input position, input status, input last,
		output ready);
endinterface

### rtl/sma_alu.sv
// Shared arithmetic unit built around one 33-bit adder. Add and subtract pass once
// through the adder, multiply is a 32-step shift-and-add, divide is a 32-step restoring
// divide on magnitudes with sign fix-up before and after.
module sma_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  sma_pkg::alu_req_t req,
	input  sma_pkg::word_t    opa,
	input  sma_pkg::word_t    opb,
	output sma_pkg::alu_rsp_t rsp,
	output sma_pkg::word_t    result
);
	import sma_pkg::*;

	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_ADD  = 3'd1;
	localparam logic [2:0] A_SUB  = 3'd2;
	localparam logic [2:0] A_MUL  = 3'd3;
	localparam logic [2:0] A_NEGN = 3'd4;
	localparam logic [2:0] A_NEGD = 3'd5;
	localparam logic [2:0] A_DIV  = 3'd6;
	localparam logic [2:0] A_NEGQ = 3'd7;

	logic [2:0]        state_q;
	logic              done_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	logic [WORD_W-1:0] z_q;
	logic [4:0]        cnt_q;
	logic              sign_q;
	logic [WORD_W-1:0] res_q;

	logic [WORD_W-1:0] rem_pre;
	logic [WORD_W-1:0] ax;
	logic [WORD_W-1:0] ay;
	logic              asub;
	logic [WORD_W:0]   ay_ext;
	logic [WORD_W:0]   sum;

	// Partial remainder shifted by one numerator bit for the next divide step.
	assign rem_pre = {x_q[WORD_W-2:0], z_q[WORD_W-1]};

	// Operand selection for the single adder.
	always_comb begin
		ax   = x_q;
		ay   = y_q;
		asub = 1'b0;
		case (state_q)
			A_SUB: begin
				asub = 1'b1;
			end
			A_NEGN, A_NEGQ: begin
				ax   = '0;
				ay   = z_q;
				asub = 1'b1;
			end
			A_NEGD: begin
				ax   = '0;
				asub = 1'b1;
			end
			A_DIV: begin
				ax   = rem_pre;
				asub = 1'b1;
			end
			default: begin
				asub = 1'b0;
			end
		endcase
	end

	assign ay_ext = asub ? ~{1'b0, ay} : {1'b0, ay};
	assign sum    = {1'b0, ax} + ay_ext + {{WORD_W{1'b0}}, asub};

	// Sequencer state and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							ALU_ADD: state_q <= A_ADD;
							ALU_SUB: state_q <= A_SUB;
							ALU_MUL: state_q <= A_MUL;
							ALU_DIV: state_q <= A_NEGN;
							default: state_q <= A_IDLE;
						endcase
					end
				end
				A_ADD, A_SUB: begin
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				A_MUL: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end
				end
				A_NEGN: state_q <= A_NEGD;
				A_NEGD: state_q <= A_DIV;
				A_DIV: begin
					if (cnt_q == '0) begin
						state_q <= A_NEGQ;
					end
				end
				A_NEGQ: begin
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// Working registers of the shared datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					// Multiply accumulates into x while z holds the multiplier.
					x_q    <= (req.op == ALU_MUL) ? '0 : opa;
					y_q    <= opb;
					z_q    <= opa;
					cnt_q  <= 5'd31;
					sign_q <= opa[WORD_W-1] ^ opb[WORD_W-1];
				end
			end
			A_ADD, A_SUB: begin
				res_q <= sum[WORD_W-1:0];
			end
			A_MUL: begin
				if (z_q[0]) begin
					x_q <= sum[WORD_W-1:0];
				end
				y_q   <= {y_q[WORD_W-2:0], 1'b0};
				z_q   <= {1'b0, z_q[WORD_W-1:1]};
				cnt_q <= cnt_q - 5'd1;
				res_q <= z_q[0] ? sum[WORD_W-1:0] : x_q;
			end
			A_NEGN: begin
				if (z_q[WORD_W-1]) begin
					z_q <= sum[WORD_W-1:0];
				end
			end
			A_NEGD: begin
				if (y_q[WORD_W-1]) begin
					y_q <= sum[WORD_W-1:0];
				end
				x_q   <= '0;
				cnt_q <= 5'd31;
			end
			A_DIV: begin
				// A clear sign bit means the divisor fits into the partial remainder.
				if (!sum[WORD_W]) begin
					x_q <= sum[WORD_W-1:0];
					z_q <= {z_q[WORD_W-2:0], 1'b1};
				end else begin
					x_q <= rem_pre;
					z_q <= {z_q[WORD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 5'd1;
			end
			A_NEGQ: begin
				res_q <= sign_q ? sum[WORD_W-1:0] : z_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp.busy = (state_q != A_IDLE);
	assign rsp.done = done_q;
	assign result   = res_q;
endmodule

### rtl/stack_machine_alu_top.sv
// Stack machine with a DEPTH-word stack held in a small on-chip memory. One instruction
// item is taken only while the sequencer is idle; each memory read is registered, and
// add, sub, mul and div go through one shared adder, where mul and div take the 32 steps
// of the shared unit. Dump reads the stack from the top word down, with one memory read
// and one output load per word. The finished result waits in an output register, so the
// next item is accepted while it is still pending. The stack needs no clearing after
// reset: an entry is always written before it is read.
module stack_machine_alu_top #(
	parameter int DEPTH = sma_pkg::DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	sma_in_if.sink    cmd,
	sma_out_if.source rsp
);
	import sma_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_RDA    = 3'd2;
	localparam logic [2:0] S_RDB    = 3'd3;
	localparam logic [2:0] S_EXEC   = 3'd4;
	localparam logic [2:0] S_POP    = 3'd5;
	localparam logic [2:0] S_DUMP   = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	// Control state.
	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          halted_q, halted_d;
	logic          out_valid_q;

	// Item and result registers.
	kind_t         kind_q;
	word_t         imm_q;
	word_t         a_q;
	logic [IW-1:0] ptr_q, ptr_d;
	word_t         res_value_q, res_value_d;
	pos_t          res_pos_q, res_pos_d;
	status_t       res_status_q, res_status_d;
	logic          res_last_q, res_last_d;
	logic          res_load;
	logic          a_load;
	word_t         out_value_q;
	pos_t          out_pos_q;
	status_t       out_status_q;
	logic          out_last_q;
	logic          out_load;

	// Stack memory ports.
	word_t         mem [DEPTH];
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	word_t         wr_data;
	logic [IW-1:0] rd_addr;
	word_t         rd_data_q;

	// Index helpers.
	logic [CW-1:0] cm1, cm2;
	logic [IW-1:0] cm1_idx, cm2_idx;
	logic          accept;

	// Shared arithmetic unit.
	alu_req_t      alu_req;
	alu_rsp_t      alu_rsp;
	word_t         alu_result;
	alu_op_t       alu_op;

	assign cm1     = count_q - CW'(1);
	assign cm2     = count_q - CW'(2);
	assign cm1_idx = cm1[IW-1:0];
	assign cm2_idx = cm2[IW-1:0];
	assign accept  = cmd.valid && cmd.ready;

	assign cmd.ready = (state_q == S_IDLE);

	// Map the opcode to the operation of the shared unit.
	always_comb begin
		case (kind_q)
			OP_SUB:  alu_op = ALU_SUB;
			OP_MUL:  alu_op = ALU_MUL;
			OP_DIV:  alu_op = ALU_DIV;
			default: alu_op = ALU_ADD;
		endcase
	end

	// Sequencer: next state, stack updates and the pending result.
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		halted_d     = halted_q;
		ptr_d        = ptr_q;
		res_load     = 1'b0;
		res_value_d  = '0;
		res_pos_d    = '0;
		res_status_d = ST_OK;
		res_last_d   = 1'b1;
		a_load       = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = count_q[IW-1:0];
		wr_data      = imm_q;
		rd_addr      = cm1_idx;
		out_load     = 1'b0;
		alu_req      = '{start: 1'b0, op: alu_op};

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_EMIT;
				if (halted_q) begin
					res_load     = 1'b1;
					res_status_d = ST_HALTED;
				end else begin
					unique case (kind_q) inside
						OP_PUSH: begin
							res_load = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								res_status_d = ST_FULL;
							end else begin
								wr_en       = 1'b1;
								res_value_d = imm_q;
								res_pos_d   = POS_W'(count_q[IW-1:0]);
								count_d     = count_q + CW'(1);
							end
						end
						OP_POP, OP_PEEK: begin
							if (count_q == '0) begin
								res_load     = 1'b1;
								res_status_d = ST_EMPTY;
							end else begin
								state_d = S_POP;
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (count_q < CW'(2)) begin
								res_load     = 1'b1;
								res_status_d = ST_EMPTY;
							end else begin
								state_d = S_RDA;
							end
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								res_load     = 1'b1;
								res_status_d = ST_EMPTY;
							end else begin
								ptr_d   = cm1_idx;
								state_d = S_DUMP;
							end
						end
						OP_EXIT: begin
							res_load = 1'b1;
							halted_d = 1'b1;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				res_load    = 1'b1;
				res_value_d = rd_data_q;
				res_pos_d   = POS_W'(cm1_idx);
				if (kind_q == OP_POP) begin
					count_d = cm1;
				end
				state_d = S_EMIT;
			end
			S_RDA: begin
				// Top word arrives; fetch the word below it.
				a_load  = 1'b1;
				rd_addr = cm2_idx;
				state_d = S_RDB;
			end
			S_RDB: begin
				if (kind_q == OP_DIV && rd_data_q == '0) begin
					res_load     = 1'b1;
					res_status_d = ST_DIVZERO;
					state_d      = S_EMIT;
				end else begin
					alu_req.start = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				if (alu_rsp.done) begin
					wr_en       = 1'b1;
					wr_addr     = cm2_idx;
					wr_data     = alu_result;
					count_d     = cm1;
					res_load    = 1'b1;
					res_value_d = alu_result;
					res_pos_d   = POS_W'(cm2_idx);
					state_d     = S_EMIT;
				end
			end
			S_DUMP: begin
				res_load    = 1'b1;
				res_value_d = rd_data_q;
				res_pos_d   = POS_W'(ptr_q);
				res_last_d  = (ptr_q == '0);
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				// Hand the result to the output register once it is free.
				rd_addr = ptr_q - IW'(1);
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					if (res_last_q) begin
						state_d = S_IDLE;
					end else begin
						ptr_d   = ptr_q - IW'(1);
						state_d = S_DUMP;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			halted_q <= halted_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, operand and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cmd.kind;
			imm_q  <= cmd.push_value;
		end
		if (a_load) begin
			a_q <= rd_data_q;
		end
		ptr_q <= ptr_d;
		if (res_load) begin
			res_value_q  <= res_value_d;
			res_pos_q    <= res_pos_d;
			res_status_q <= res_status_d;
			res_last_q   <= res_last_d;
		end
		if (out_load) begin
			out_value_q  <= res_value_q;
			out_pos_q    <= res_pos_q;
			out_status_q <= res_status_q;
			out_last_q   <= res_last_q;
		end
	end

	// Stack memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	sma_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (a_q),
		.opb    (rd_data_q),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	assign rsp.valid    = out_valid_q;
	assign rsp.value    = out_value_q;
	assign rsp.position = out_pos_q;
	assign rsp.status   = out_status_q;
	assign rsp.last     = out_last_q;

	// The stack never holds more than DEPTH words.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack count exceeds depth");

	// The arithmetic unit only finishes while the sequencer waits for it.
	a_alu_done_exec: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_EXEC)
		else $error("arithmetic result arrived outside execute");

	// A new item is never taken while the arithmetic unit is still working.
	a_idle_alu_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !alu_rsp.busy)
		else $error("arithmetic unit busy while idle");

	// The stack count changes only while an item is being worked on.
	a_count_stable_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> count_q == $past(count_q))
		else $error("stack count changed while idle");
endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sma_pkg::*;

	localparam int    STACK_DEPTH   = DEPTH_DEFAULT;
	localparam int    WATCHDOG_MAX  = 2000;
	localparam int    DRAIN_CYCLES  = 60;
	localparam int    REPORT_MAX    = 10;
	localparam word_t WORD_MIN      = word_t'(32'h8000_0000);
	localparam word_t WORD_MAX      = word_t'(32'h7FFF_FFFF);

	// One result item as the block reports it.
	typedef struct {
		word_t   value;
		pos_t    position;
		status_t status;
		logic    last;
	} stack_result_t;

	logic clk;
	logic arst_n;

	sma_in_if  cmd_if ();
	sma_out_if rsp_if ();

	stack_machine_alu_top #(
		.DEPTH (STACK_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	// Shadow copy of the machine, updated when an instruction is accepted.
	word_t         stack_mem [STACK_DEPTH];
	int unsigned   stack_count;
	bit            machine_halted;
	stack_result_t pending_results [$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_request;
	int unsigned hold_left;
	int unsigned mismatch_count;
	int unsigned quiet_cycles;

	// Clock with a 10 ns period.
	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Signed division that truncates toward zero; the most negative word over
	// minus one wraps back to the most negative word.
	function automatic word_t trunc_quotient(word_t num, word_t den);
		logic [WORD_W-1:0] num_mag;
		logic [WORD_W-1:0] den_mag;
		logic [WORD_W-1:0] quo;
		num_mag = num[WORD_W-1] ? (32'd0 - num) : num;
		den_mag = den[WORD_W-1] ? (32'd0 - den) : den;
		quo     = num_mag / den_mag;
		return (num[WORD_W-1] != den[WORD_W-1]) ? word_t'(32'd0 - quo) : word_t'(quo);
	endfunction

	function automatic void add_expected(word_t value, int unsigned index, status_t status,
			logic last);
		stack_result_t item;
		item.value    = value;
		item.position = pos_t'(index);
		item.status   = status;
		item.last     = last;
		pending_results.push_back(item);
	endfunction

	// Carries out one instruction on the shadow stack and queues its results.
	function automatic void execute_instr(kind_t kind, word_t imm);
		word_t       top_word;
		word_t       below_word;
		word_t       outcome;
		int unsigned dst;
		if (machine_halted) begin
			add_expected('0, 0, ST_HALTED, 1'b1);
			return;
		end
		case (kind)
			OP_PUSH: begin
				if (stack_count >= STACK_DEPTH) begin
					add_expected('0, 0, ST_FULL, 1'b1);
				end else begin
					stack_mem[stack_count] = imm;
					add_expected(imm, stack_count, ST_OK, 1'b1);
					stack_count++;
				end
			end
			OP_POP, OP_PEEK: begin
				if (stack_count == 0) begin
					add_expected('0, 0, ST_EMPTY, 1'b1);
				end else begin
					add_expected(stack_mem[stack_count-1], stack_count - 1, ST_OK, 1'b1);
					if (kind == OP_POP)
						stack_count--;
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (stack_count < 2) begin
					add_expected('0, 0, ST_EMPTY, 1'b1);
				end else begin
					top_word   = stack_mem[stack_count-1];
					below_word = stack_mem[stack_count-2];
					dst        = stack_count - 2;
					if (kind == OP_DIV && below_word == '0) begin
						add_expected('0, 0, ST_DIVZERO, 1'b1);
					end else begin
						case (kind)
							OP_ADD:  outcome = below_word + top_word;
							OP_SUB:  outcome = top_word - below_word;
							OP_MUL:  outcome = top_word * below_word;
							default: outcome = trunc_quotient(top_word, below_word);
						endcase
						stack_mem[dst] = outcome;
						stack_count--;
						add_expected(outcome, dst, ST_OK, 1'b1);
					end
				end
			end
			OP_DUMP: begin
				if (stack_count == 0) begin
					add_expected('0, 0, ST_EMPTY, 1'b1);
				end else begin
					for (int idx = stack_count - 1; idx >= 0; idx--)
						add_expected(stack_mem[idx], idx, ST_OK, idx == 0);
				end
			end
			OP_EXIT: begin
				machine_halted = 1'b1;
				add_expected('0, 0, ST_OK, 1'b1);
			end
			default: begin
				add_expected('0, 0, ST_OK, 1'b1);
			end
		endcase
	endfunction

	// Operand words lean toward the extremes and small values.
	function automatic word_t rand_word();
		case ($urandom_range(0, 7))
			0:       return WORD_MIN;
			1:       return WORD_MAX;
			2:       return word_t'(-1);
			3:       return '0;
			4:       return word_t'($urandom_range(0, 20)) - word_t'(10);
			default: return word_t'($urandom);
		endcase
	endfunction

	// Keeps the stack mostly between empty and full, with a little noise of
	// unused opcodes and the odd error.
	function automatic kind_t pick_kind();
		int unsigned roll;
		int unsigned pick;
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			pick = $urandom_range(0, 6);
			return (pick == 0) ? OP_NOP : kind_t'(OP_EXIT + pick);
		end
		if (stack_count < 2 && roll < 70)
			return OP_PUSH;
		if (stack_count >= STACK_DEPTH - 1 && roll < 60)
			return kind_t'($urandom_range(OP_POP, OP_PEEK));
		pick = $urandom_range(0, 9);
		return (pick >= 8) ? OP_PUSH : kind_t'(pick);
	endfunction

	// Offers one item, with random idle cycles first, and waits for acceptance.
	task automatic send_instr(input kind_t kind, input word_t imm);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_if.valid      <= 1'b0;
			cmd_if.kind       <= kind_t'($urandom);
			cmd_if.push_value <= word_t'($urandom);
			@(posedge clk);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.kind       <= kind;
		cmd_if.push_value <= imm;
		do
			@(posedge clk);
		while (cmd_if.ready !== 1'b1);
		execute_instr(kind, imm);
	endtask

	// Stops offering items until every queued result has come back.
	task automatic wait_for_results();
		cmd_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			rsp_if.ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Compares every accepted result with the oldest expectation.
	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("%0t: result with none expected: value=%0d pos=%0d status=%0d last=%0b",
						$realtime, rsp_if.value, rsp_if.position, rsp_if.status, rsp_if.last);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.value !== want.value || rsp_if.position !== want.position ||
						rsp_if.status !== want.status || rsp_if.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display({"%0t: mismatch: expected value=%0d pos=%0d status=%0d last=%0b,",
							" got value=%0d pos=%0d status=%0d last=%0b"}, $realtime,
							want.value, want.position, want.status, want.last,
							rsp_if.value, rsp_if.position, rsp_if.status, rsp_if.last);
				end
			end
		end
	end

	// Ends the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
					(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_MAX);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Errors on an empty stack, every operation, wrap cases and division corners.
	task automatic test_directed_ops();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_instr(OP_POP, '0);
		send_instr(OP_PEEK, '0);
		send_instr(OP_DUMP, '0);
		send_instr(OP_PUSH, word_t'(-1));
		send_instr(OP_ADD, '0);
		send_instr(OP_PUSH, WORD_MIN);
		send_instr(OP_DIV, '0);
		send_instr(OP_PUSH, '0);
		send_instr(OP_PUSH, word_t'(7));
		send_instr(OP_DIV, '0);
		send_instr(OP_POP, '0);
		send_instr(OP_PUSH, WORD_MAX);
		send_instr(OP_ADD, '0);
		send_instr(OP_SUB, '0);
		send_instr(OP_PUSH, word_t'(3));
		send_instr(OP_MUL, '0);
		send_instr(OP_PUSH, word_t'(2));
		send_instr(OP_PUSH, word_t'(-7));
		send_instr(OP_DIV, '0);
		send_instr(OP_PEEK, '0);
		send_instr(OP_NOP, word_t'($urandom));
		send_instr(kind_t'('1), word_t'($urandom));
		wait_for_results();
	endtask

	// Fills the stack, pushes once more onto the full stack, then dumps it.
	task automatic test_full_stack();
		while (stack_count < STACK_DEPTH)
			send_instr(OP_PUSH, rand_word());
		send_instr(OP_PUSH, word_t'($urandom));
		send_instr(OP_DUMP, '0);
		wait_for_results();
	endtask

	// Random instruction mix under one setting of sender idling and receiver stalls.
	task automatic test_random_mix(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned n_items);
		kind_t kind;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n_items) begin
			kind = pick_kind();
			send_instr(kind, rand_word());
		end
		wait_for_results();
	endtask

	// The receiver holds off for a long stretch while items keep coming, so the
	// block backs up and stalls its input.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 150;
		repeat (12)
			send_instr(pick_kind(), rand_word());
		wait_for_results();
	endtask

	// Exit, then every opcode is refused.
	task automatic test_halt();
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		send_instr(OP_EXIT, word_t'($urandom));
		for (int code = 0; code < (1 << KIND_W); code++)
			send_instr(kind_t'(code), rand_word());
		wait_for_results();
	endtask

	initial begin
		arst_n            = 1'b0;
		cmd_if.valid      = 1'b0;
		cmd_if.kind       = OP_NOP;
		cmd_if.push_value = '0;
		stack_count       = 0;
		machine_halted    = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		hold_request      = 0;
		hold_left         = 0;
		mismatch_count    = 0;
		quiet_cycles      = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_full_stack();
		test_random_mix(0, 0, 85);
		test_random_mix(61, 0, 85);
		test_random_mix(0, 61, 85);
		test_random_mix(20, 20, 90);
		test_backpressure();
		test_halt();

		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
